// ===== rtl/hbp_pkg.sv =====
// hbp_pkg: shared types and constants for the Huffman bit packer.
// Used by the channel interfaces, the code table, controller, datapath and top level.
// No dependencies.
package hbp_pkg;

  // Request field widths
  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int VAL_W  = 48;
  localparam int LENI_W = 6;
  localparam int BYTE_W = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_MERGE,
    ST_EMIT,
    ST_FLUSH
  } hbp_state_t;

  // Controller -> datapath/table commands
  typedef struct packed {
    logic tbl_wr;
    logic tbl_rd;
    logic align;
    logic merge;
    logic emit;
    logic commit;
    logic flush_emit;
  } hbp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic ge8;
    logic pend_any;
    logic slot_free;
  } hbp_stat_t;

endpackage

// ===== rtl/hbp_in_if.sv =====
// hbp_in_if: request channel (valid/ready) carrying command, symbol and code fields.
// Depends on hbp_pkg for field widths.
interface hbp_in_if;
  logic                         valid;
  logic                         ready;
  logic [hbp_pkg::CMD_W-1:0]    command;
  logic [hbp_pkg::SYM_W-1:0]    symbol;
  logic [hbp_pkg::VAL_W-1:0]    code_value;
  logic [hbp_pkg::LENI_W-1:0]   code_length;

  modport source (output valid, output command, output symbol, output code_value,
                  output code_length, input ready);
  modport sink   (input valid, input command, input symbol, input code_value,
                  input code_length, output ready);
endinterface

// ===== rtl/hbp_out_if.sv =====
// hbp_out_if: result channel (valid/ready) carrying one packed byte and its run marker.
// Depends on hbp_pkg for field widths.
interface hbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hbp_pkg::BYTE_W-1:0]   packed_byte;
  logic                         last_of_run;

  modport source (output valid, output packed_byte, output last_of_run, input ready);
  modport sink   (input valid, input packed_byte, input last_of_run, output ready);
endinterface

// ===== rtl/hbp_code_table.sv =====
// hbp_code_table: per-symbol code/length store with a valid bit per entry.
// Registered read port; entries never loaded read as length zero. Depends on hbp_pkg.
module hbp_code_table #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [hbp_pkg::SYM_W-1:0]         wr_sym,
  input  logic [hbp_pkg::VAL_W-1:0]         wr_code,
  input  logic [hbp_pkg::LENI_W-1:0]        wr_len,
  input  logic                              rd_en,
  input  logic [hbp_pkg::SYM_W-1:0]         rd_sym,
  output logic [((MAX_CODE_BITS < hbp_pkg::VAL_W) ? MAX_CODE_BITS
                 : hbp_pkg::VAL_W)-1:0]     rd_code,
  output logic [$clog2(MAX_CODE_BITS+1)-1:0] rd_len
);

  localparam int CODE_W = (MAX_CODE_BITS < hbp_pkg::VAL_W) ? MAX_CODE_BITS : hbp_pkg::VAL_W;
  localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENT_W  = CODE_W + LEN_W;

  logic [ENT_W-1:0]          mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]   vld_r;
  logic [ENT_W-1:0]          rd_q_r;
  logic                      rd_hit_r;

  logic                      wr_in_range;
  logic                      rd_in_range;
  logic [IDX_W-1:0]          wr_idx;
  logic [IDX_W-1:0]          rd_idx;
  logic [hbp_pkg::VAL_W-1:0] wr_mask;
  logic [LEN_W-1:0]          wr_len_clamped;

  assign wr_in_range = int'(wr_sym) < SYMBOL_COUNT;
  assign rd_in_range = int'(rd_sym) < SYMBOL_COUNT;
  assign wr_idx      = wr_sym[IDX_W-1:0];
  assign rd_idx      = rd_sym[IDX_W-1:0];

  // bits above the code length are dropped; shifts past 48 leave all ones
  assign wr_mask        = ~({hbp_pkg::VAL_W{1'b1}} << wr_len);
  assign wr_len_clamped = (int'(wr_len) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                          : LEN_W'(wr_len);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_idx] <= {wr_len_clamped, CODE_W'(wr_code & wr_mask)};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en && wr_in_range) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= rd_in_range && vld_r[rd_idx];
      end
    end
  end

  assign rd_code = rd_hit_r ? rd_q_r[CODE_W-1:0]     : '0;
  assign rd_len  = rd_hit_r ? rd_q_r[ENT_W-1:CODE_W] : '0;

endmodule

// ===== rtl/hbp_ctrl.sv =====
// hbp_ctrl: sequencing state machine for load, encode and flush requests.
// Drives hbp_cmd_t commands from hbp_stat_t status. Depends on hbp_pkg.
module hbp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [hbp_pkg::CMD_W-1:0]  in_command,
  output logic                       in_ready,
  input  hbp_pkg::hbp_stat_t         stat,
  output hbp_pkg::hbp_cmd_t          cmd
);

  hbp_pkg::hbp_state_t state_r;
  hbp_pkg::hbp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      hbp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            hbp_pkg::CMD_LOAD: begin
              cmd.tbl_wr = 1'b1;
            end
            hbp_pkg::CMD_ENCODE: begin
              cmd.tbl_rd = 1'b1;
              state_nxt  = hbp_pkg::ST_ALIGN;
            end
            hbp_pkg::CMD_FLUSH: begin
              state_nxt = hbp_pkg::ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      hbp_pkg::ST_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = hbp_pkg::ST_MERGE;
      end
      hbp_pkg::ST_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = hbp_pkg::ST_EMIT;
      end
      hbp_pkg::ST_EMIT: begin
        if (stat.ge8) begin
          cmd.emit = stat.slot_free;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = hbp_pkg::ST_IDLE;
        end
      end
      hbp_pkg::ST_FLUSH: begin
        if (!stat.pend_any) begin
          state_nxt = hbp_pkg::ST_IDLE;
        end else if (stat.slot_free) begin
          cmd.flush_emit = 1'b1;
          state_nxt      = hbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hbp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hbp_datapath.sv =====
// hbp_datapath: code alignment, merge with pending bits, byte shift register,
// pending byte and output register. Depends on hbp_pkg.
module hbp_datapath #(
  parameter int MAX_CODE_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hbp_pkg::hbp_cmd_t                  cmd,
  output hbp_pkg::hbp_stat_t                 stat,
  input  logic [((MAX_CODE_BITS < hbp_pkg::VAL_W) ? MAX_CODE_BITS
                 : hbp_pkg::VAL_W)-1:0]      rd_code,
  input  logic [$clog2(MAX_CODE_BITS+1)-1:0] rd_len,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [hbp_pkg::BYTE_W-1:0]         out_packed_byte,
  output logic                               out_last_of_run
);

  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int TOT_W = $clog2(MAX_CODE_BITS + hbp_pkg::BYTE_W);
  localparam int SR_W  = hbp_pkg::BYTE_W + MAX_CODE_BITS;
  localparam int B_W   = hbp_pkg::BYTE_W;

  logic [MAX_CODE_BITS-1:0] code_left_r;
  logic [SR_W-1:0]          sr_r;
  logic [TOT_W-1:0]         total_r;
  logic [B_W-1:0]           pend_r;     // left aligned, zeros below the count
  logic [2:0]               cnt_r;
  logic                     out_valid_r;
  logic [B_W-1:0]           out_byte_r;
  logic                     out_last_r;

  logic [MAX_CODE_BITS-1:0] code_ext;
  logic [LEN_W-1:0]         align_sh;
  logic [TOT_W-1:0]         total_sub;

  assign code_ext  = MAX_CODE_BITS'(rd_code);
  assign align_sh  = LEN_W'(MAX_CODE_BITS) - rd_len;
  assign total_sub = total_r - TOT_W'(B_W);

  // align code to the top, then place it right after the pending bits
  always_ff @(posedge clk) begin
    if (cmd.align) begin
      code_left_r <= code_ext << align_sh;
      total_r     <= TOT_W'(cnt_r) + TOT_W'(rd_len);
    end else if (cmd.emit) begin
      total_r     <= total_sub;
    end
    if (cmd.merge) begin
      sr_r <= {pend_r, {MAX_CODE_BITS{1'b0}}} | ({code_left_r, {B_W{1'b0}}} >> cnt_r);
    end else if (cmd.emit) begin
      sr_r <= sr_r << B_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.commit) begin
      pend_r <= sr_r[SR_W-1 -: B_W];
      cnt_r  <= total_r[2:0];
    end else if (cmd.flush_emit) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.flush_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= sr_r[SR_W-1 -: B_W];
      out_last_r <= ~|total_sub[TOT_W-1:3];
    end else if (cmd.flush_emit) begin
      out_byte_r <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  assign stat.ge8       = |total_r[TOT_W-1:3];
  assign stat.pend_any  = |cnt_r;
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_packed_byte = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== rtl/huffman_bit_packer.sv =====
// Huffman bit packer, MSB first. Load writes one table entry; flush sends out the pending byte, if any.
// Encode: one emit step per byte produced (up to (7+MAX_CODE_BITS)/8 bytes);
// the byte shift register releases one byte per cycle into a single output register, while it is free.
// Output: an accepted encode request passes the ALIGN, MERGE and EMIT states before its first byte is registered.
// Reset (synchronous, rst_n low) clears every table valid bit, so all lengths read zero,
// and clears the pending bit count; the table needs no clearing pass.
module huffman_bit_packer #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  hbp_in_if.sink    in_if,
  hbp_out_if.source out_if
);

  localparam int CODE_W = (MAX_CODE_BITS < hbp_pkg::VAL_W) ? MAX_CODE_BITS : hbp_pkg::VAL_W;
  localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);

  hbp_pkg::hbp_cmd_t  cmd;
  hbp_pkg::hbp_stat_t stat;
  logic [CODE_W-1:0]  rd_code;
  logic [LEN_W-1:0]   rd_len;

  hbp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  hbp_code_table #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd.tbl_wr),
    .wr_sym  (in_if.symbol),
    .wr_code (in_if.code_value),
    .wr_len  (in_if.code_length),
    .rd_en   (cmd.tbl_rd),
    .rd_sym  (in_if.symbol),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  hbp_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .rd_code         (rd_code),
    .rd_len          (rd_len),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_packed_byte (out_if.packed_byte),
    .out_last_of_run (out_if.last_of_run)
  );

endmodule
